@@ src/rc4_pkg.sv @@
// Shared types and constants for the RC4 keystream cipher.
// Holds the request/result structs, command and register codes and the sequencer states.
// No dependencies.
`default_nettype none

package rc4_pkg;

  // Key length in bytes used by the key schedule (1 to 16).
  localparam int KEY_BYTES = 16;
  localparam int KIDX_W    = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  // Permutation memory geometry.
  localparam int PERM_DEPTH = 256;
  localparam int PERM_AW    = 8;
  localparam logic [PERM_AW-1:0] PERM_LAST = PERM_AW'(PERM_DEPTH - 1);

  // Configuration port.
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 1'b1;

  // Request commands.
  localparam logic CMD_REKEY = 1'b0;
  localparam logic CMD_CRYPT = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] data_in;
  } in_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       rekey_done;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_RD_I,
    ST_RD_J,
    ST_WR_I,
    ST_WR_J,
    ST_RD_T,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ src/rc4_ram.sv @@
// Generic single-port RAM with registered read (read-first on a write).
// No dependencies.
`default_nettype none

module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle; the read returns the contents before any write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

@@ src/rc4_engine.sv @@
// Sequencer and datapath for RC4: fill, key schedule and byte crypt on one memory port.
// Depends on rc4_pkg and rc4_ram.
`default_nettype none

module rc4_engine (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire rc4_pkg::in_t                      in_data,
  input  wire logic [rc4_pkg::CFG_DATA_W-1:0]    key_low,
  input  wire logic [rc4_pkg::CFG_DATA_W-1:0]    key_high,
  output logic                                   res_valid,
  input  wire logic                              res_ready,
  output rc4_pkg::out_t                          res_data
);

  rc4_pkg::state_t state_r, state_nxt;

  logic [rc4_pkg::PERM_AW-1:0] i_r, i_nxt;
  logic [rc4_pkg::PERM_AW-1:0] j_r, j_nxt;
  logic [rc4_pkg::KIDX_W-1:0]  kidx_r, kidx_nxt;
  logic [7:0]                  si_r, si_nxt;
  logic [7:0]                  sj_r, sj_nxt;
  logic                        cmd_r, cmd_nxt;
  logic [7:0]                  data_r, data_nxt;

  logic                        ram_we;
  logic [rc4_pkg::PERM_AW-1:0] ram_addr;
  logic [7:0]                  ram_wdata;
  logic [7:0]                  ram_rdata;

  logic [2*rc4_pkg::CFG_DATA_W-1:0] key_all;
  logic [7:0]                       key_byte;
  logic [7:0]                       key_add;
  logic [rc4_pkg::PERM_AW-1:0]      j_step;
  logic [rc4_pkg::PERM_AW-1:0]      t_addr;

  // Permutation memory.
  rc4_ram #(
    .WIDTH (8),
    .DEPTH (rc4_pkg::PERM_DEPTH)
  ) u_perm (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Key byte for the current schedule step; only the schedule adds it to j.
  assign key_all  = {key_high, key_low};
  assign key_byte = key_all[{kidx_r, 3'b000} +: 8];
  assign key_add  = (cmd_r == rc4_pkg::CMD_REKEY) ? key_byte : 8'h00;

  // Shared adders: new j, and the keystream address S[i] + S[j].
  assign j_step = j_r + ram_rdata + key_add;
  assign t_addr = si_r + sj_r;

  assign in_ready = (state_r == rc4_pkg::ST_IDLE);

  // State and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rc4_pkg::ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      kidx_r  <= '0;
      cmd_r   <= rc4_pkg::CMD_REKEY;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      kidx_r  <= kidx_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    si_r   <= si_nxt;
    sj_r   <= sj_nxt;
    data_r <= data_nxt;
  end

  // Next state, memory port control and result.
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    kidx_nxt  = kidx_r;
    si_nxt    = si_r;
    sj_nxt    = sj_r;
    cmd_nxt   = cmd_r;
    data_nxt  = data_r;
    ram_we    = 1'b0;
    ram_addr  = i_r;
    ram_wdata = i_r;
    res_valid = 1'b0;
    res_data.data_out   = (cmd_r == rc4_pkg::CMD_CRYPT) ? (ram_rdata ^ data_r) : 8'h00;
    res_data.rekey_done = (cmd_r == rc4_pkg::CMD_REKEY);

    case (state_r)
      rc4_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt  = in_data.command;
          data_nxt = in_data.data_in;
          if (in_data.command == rc4_pkg::CMD_CRYPT) begin
            i_nxt     = i_r + 1'b1;
            state_nxt = rc4_pkg::ST_RD_I;
          end else begin
            i_nxt     = '0;
            j_nxt     = '0;
            kidx_nxt  = '0;
            state_nxt = rc4_pkg::ST_FILL;
          end
        end
      end

      // Load the identity permutation, one entry a cycle.
      rc4_pkg::ST_FILL: begin
        ram_we    = 1'b1;
        ram_addr  = i_r;
        ram_wdata = i_r;
        i_nxt     = i_r + 1'b1;
        if (i_r == rc4_pkg::PERM_LAST) begin
          state_nxt = rc4_pkg::ST_RD_I;
        end
      end

      rc4_pkg::ST_RD_I: begin
        ram_addr  = i_r;
        state_nxt = rc4_pkg::ST_RD_J;
      end

      // S[i] arrives: form the new j and read S[j].
      rc4_pkg::ST_RD_J: begin
        si_nxt    = ram_rdata;
        j_nxt     = j_step;
        ram_addr  = j_step;
        state_nxt = rc4_pkg::ST_WR_I;
      end

      // S[j] arrives: first half of the swap.
      rc4_pkg::ST_WR_I: begin
        ram_we    = 1'b1;
        ram_addr  = i_r;
        ram_wdata = ram_rdata;
        sj_nxt    = ram_rdata;
        state_nxt = rc4_pkg::ST_WR_J;
      end

      // Second half of the swap; the schedule loops, a crypt goes on to the keystream read.
      rc4_pkg::ST_WR_J: begin
        ram_we    = 1'b1;
        ram_addr  = j_r;
        ram_wdata = si_r;
        if (cmd_r == rc4_pkg::CMD_REKEY) begin
          i_nxt    = i_r + 1'b1;
          kidx_nxt = (kidx_r == rc4_pkg::KIDX_W'(rc4_pkg::KEY_BYTES - 1)) ?
                     '0 : kidx_r + 1'b1;
          if (i_r == rc4_pkg::PERM_LAST) begin
            j_nxt     = '0;
            state_nxt = rc4_pkg::ST_DONE;
          end else begin
            state_nxt = rc4_pkg::ST_RD_I;
          end
        end else begin
          state_nxt = rc4_pkg::ST_RD_T;
        end
      end

      rc4_pkg::ST_RD_T: begin
        ram_addr  = t_addr;
        state_nxt = rc4_pkg::ST_DONE;
      end

      // Hold the keystream address so the read data stays put while the result waits.
      rc4_pkg::ST_DONE: begin
        ram_addr  = t_addr;
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = rc4_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = rc4_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/rc4_keystream_cipher.sv @@
// Top level of the RC4 keystream cipher: key registers, engine and output register.
// Depends on rc4_pkg, rc4_engine and rc4_ram.
//
//   Port group   Direction  Handshake          Payload
//   in_*         input      in_valid/in_ready  rc4_pkg::in_t  (command, data_in)
//   out_*        output     out_valid/out_ready rc4_pkg::out_t (data_out, rekey_done)
//   cfg_*        input      cfg_we (no wait)   cfg_index, cfg_data (64 bits)
//
// A crypt request goes from acceptance to a result in the output register through the
// single memory port: read S[i], read S[j], two swap writes, keystream read.
// A rekey request runs the identity fill and then the key schedule,
// both through the same port.
// Reset is synchronous and active low; it clears the indices and the key registers.
// The engine accepts one request at a time; a stalled result holds the engine until taken.
`default_nettype none

module rc4_keystream_cipher (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire rc4_pkg::in_t                      in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output rc4_pkg::out_t                          out_data,
  input  wire logic                              cfg_we,
  input  wire logic [rc4_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rc4_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [rc4_pkg::CFG_DATA_W-1:0] key_low_r;
  logic [rc4_pkg::CFG_DATA_W-1:0] key_high_r;
  logic                           out_valid_r;
  rc4_pkg::out_t                  out_data_r;
  logic                           res_valid;
  logic                           res_ready;
  rc4_pkg::out_t                  res_data;

  // Key registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rc4_pkg::CFG_KEY_LOW:  key_low_r  <= cfg_data;
        rc4_pkg::CFG_KEY_HIGH: key_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  rc4_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .key_low   (key_low_r),
    .key_high  (key_high_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  // Output register: loads when empty or being drained.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ src/rc4_chk.sv @@
// Port-level checker for the RC4 keystream cipher, bound to the top level.
// Depends on rc4_pkg and rc4_keystream_cipher.
`default_nettype none

module rc4_chk (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire rc4_pkg::out_t                     out_data
);

  // A result waiting on the consumer keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // After a request is taken the block stays busy and does not accept another at once.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("request accepted while busy");

  // A rekey answer carries a zero data byte.
  a_rekey_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rekey_done |-> out_data.data_out == 8'h00)
    else $error("rekey result with non-zero data");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind rc4_keystream_cipher rc4_chk u_rc4_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
